// ===== rtl/i2cm_pkg.sv =====
`default_nettype none
package i2cm_pkg;

  // Command codes carried in the operation field
  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_WRITE    = 3'd2,
    OP_READ     = 3'd3,
    OP_ACK      = 3'd4,
    OP_NACK     = 3'd5,
    OP_WAIT_ACK = 3'd6
  } op_t;

  // Bus phases; each holds for the configured number of ticks
  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST_A = 5'd1,
    PH_ST_B = 5'd2,
    PH_ST_C = 5'd3,
    PH_SP_A = 5'd4,
    PH_SP_B = 5'd5,
    PH_SP_C = 5'd6,
    PH_SP_D = 5'd7,
    PH_AK_A = 5'd8,
    PH_AK_B = 5'd9,
    PH_AK_C = 5'd10,
    PH_AK_D = 5'd11,
    PH_WR_A = 5'd12,
    PH_WR_B = 5'd13,
    PH_WR_C = 5'd14,
    PH_WR_E = 5'd15,
    PH_RD_R = 5'd16,
    PH_RD_A = 5'd17,
    PH_RD_B = 5'd18,
    PH_RD_E = 5'd19,
    PH_WA_R = 5'd20,
    PH_WA_H = 5'd21,
    PH_WA_P = 5'd22,
    PH_WA_E = 5'd23
  } phase_t;

  // Configuration register indexes
  localparam logic CFG_PHASE_TICKS    = 1'b0;
  localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

  localparam logic [7:0] PHASE_TICKS_RST    = 8'd1;
  localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd250;

  // One result as handed from the sequencer to the output stage
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/i2cm_if.sv =====
`default_nettype none
// Tick channel into the block
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] operation;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, cmd_valid, operation, write_data, sda_in, input ready);
  modport sink   (input valid, cmd_valid, operation, write_data, sda_in, output ready);
endinterface

// Result channel out of the block
interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_missing;

  modport source (output valid, scl_level, sda_release, busy_res, done_res, read_data,
                  ack_missing, input ready);
  modport sink   (input valid, scl_level, sda_release, busy_res, done_res, read_data,
                  ack_missing, output ready);
endinterface
`default_nettype wire

// ===== rtl/i2c_bit_level_master_top.sv =====
`default_nettype none
// Bit-level I2C master sequencer. Every request on in_chan is one timing tick
// and yields exactly one result on out_chan carrying the SCL and SDA levels to
// drive, busy and done flags, the last read byte and the missing-ack flag.
// A command on a tick is acted on only while idle, else ignored; it then runs as
// a chain of bus phases, each held for phase_ticks ticks (zero counts as one).
// Bytes go out MSB first; read bits are sampled at the end of the SCL-high
// phase; wait-ack tolerates ack_poll_limit high samples, gives up on the next
// high one, issues a stop and sets ack_missing. One tick is taken per clock:
// the sequencer state steps once per accepted request and the result register
// frees in the same cycle it is read, so the rate is set only by how fast the
// result side drains. Configuration writes take effect at the next edge; the
// user must make them only while idle, which the block does not enforce.
module i2c_bit_level_master_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  i2cm_in_if.sink         in_chan,
  i2cm_out_if.source      out_chan
);
  import i2cm_pkg::*;

  logic ready;
  logic step;
  res_t res;

  assign in_chan.ready = ready;
  assign step          = in_chan.valid && ready;

  i2cm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .cmd_valid  (in_chan.cmd_valid),
    .operation  (in_chan.operation),
    .write_data (in_chan.write_data),
    .sda_in     (in_chan.sda_in),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .res        (res)
  );

  i2cm_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .res      (res),
    .in_ready (ready),
    .out_ch   (out_chan)
  );

endmodule
`default_nettype wire

// ===== rtl/i2cm_seq.sv =====
`default_nettype none
module i2cm_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic          cmd_valid,
  input  wire logic [2:0]    operation,
  input  wire logic [7:0]    write_data,
  input  wire logic          sda_in,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [7:0]    cfg_wdata,
  output i2cm_pkg::res_t     res
);
  import i2cm_pkg::*;

  logic [7:0] phase_ticks_r, ack_poll_limit_r;
  phase_t     phase_r, phase_nxt;
  op_t        cmd_r, cmd_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_err_r, ack_err_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic       done;
  logic       enter_en;
  phase_t     enter_ph;
  logic [7:0] pt;
  logic       tick_end;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r    <= PHASE_TICKS_RST;
      ack_poll_limit_r <= ACK_POLL_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PHASE_TICKS) phase_ticks_r <= cfg_wdata;
      else                              ack_poll_limit_r <= cfg_wdata;
    end
  end

  // Phase length, a zero setting counts as one tick
  assign pt       = (phase_ticks_r == 8'd0) ? 8'd1 : phase_ticks_r;
  assign tick_end = ({1'b0, tick_r} + 9'd1) >= {1'b0, pt};

  // Next sequencer state for one tick
  always_comb begin
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    tick_nxt    = tick_r;
    poll_nxt    = poll_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    ack_err_nxt = ack_err_r;
    rx_nxt      = rx_r;
    done        = 1'b0;
    enter_en    = 1'b0;
    enter_ph    = PH_IDLE;

    if (phase_r == PH_IDLE) begin
      // Take a new command; an unknown code leaves the block idle
      if (cmd_valid) begin
        case (op_t'(operation))
          OP_START: begin
            enter_en = 1'b1; enter_ph = PH_ST_A;
          end
          OP_STOP: begin
            enter_en = 1'b1; enter_ph = PH_SP_A;
          end
          OP_WRITE: begin
            shift_nxt = write_data;
            enter_en  = 1'b1; enter_ph = PH_WR_A;
          end
          OP_READ: begin
            shift_nxt = 8'd0;
            enter_en  = 1'b1; enter_ph = PH_RD_R;
          end
          OP_ACK, OP_NACK: begin
            enter_en = 1'b1; enter_ph = PH_AK_A;
          end
          OP_WAIT_ACK: begin
            ack_err_nxt = 1'b0;
            poll_nxt    = 8'd0;
            enter_en    = 1'b1; enter_ph = PH_WA_R;
          end
          default: ;
        endcase
        if (enter_en) begin
          cmd_nxt = op_t'(operation);
          bit_nxt = 4'd0;
        end
      end
    end else if (tick_end) begin
      // Phase has run its length: move on
      case (phase_r)
        PH_ST_C, PH_SP_D, PH_AK_D, PH_WR_E, PH_WA_E: begin
          phase_nxt = PH_IDLE; tick_nxt = 8'd0; done = 1'b1;
        end
        PH_RD_E: begin
          rx_nxt    = shift_r;
          phase_nxt = PH_IDLE; tick_nxt = 8'd0; done = 1'b1;
        end
        PH_WR_C: begin
          bit_nxt  = bit_r + 4'd1;
          enter_en = 1'b1;
          enter_ph = bit_nxt[3] ? PH_WR_E : PH_WR_A;
        end
        PH_RD_B: begin
          shift_nxt = {shift_r[6:0], sda_in};
          bit_nxt   = bit_r + 4'd1;
          enter_en  = 1'b1;
          enter_ph  = bit_nxt[3] ? PH_RD_E : PH_RD_A;
        end
        PH_WA_H, PH_WA_P: begin
          enter_en = 1'b1;
          if (!sda_in) begin
            enter_ph = PH_WA_E;
          end else if (poll_r >= ack_poll_limit_r) begin
            ack_err_nxt = 1'b1;
            enter_ph    = PH_SP_A;
          end else begin
            poll_nxt = poll_r + 8'd1;
            enter_ph = PH_WA_P;
          end
        end
        default: begin
          if (phase_r > PH_WA_E) begin
            phase_nxt = PH_IDLE; tick_nxt = 8'd0; done = 1'b1;
          end else begin
            enter_en = 1'b1;
            enter_ph = phase_t'(phase_r + 5'd1);
          end
        end
      endcase
    end else begin
      tick_nxt = tick_r + 8'd1;
    end

    // Line changes made on entry to a phase
    if (enter_en) begin
      phase_nxt = enter_ph;
      tick_nxt  = 8'd0;
      case (enter_ph)
        PH_ST_A: begin sda_nxt = 1'b1; scl_nxt = 1'b1; end
        PH_ST_B: sda_nxt = 1'b0;
        PH_ST_C: scl_nxt = 1'b0;
        PH_SP_A: scl_nxt = 1'b0;
        PH_SP_B: sda_nxt = 1'b0;
        PH_SP_C: scl_nxt = 1'b1;
        PH_SP_D: sda_nxt = 1'b1;
        PH_AK_A: scl_nxt = 1'b0;
        PH_AK_B: sda_nxt = (cmd_nxt == OP_NACK);
        PH_AK_C: scl_nxt = 1'b1;
        PH_AK_D: scl_nxt = 1'b0;
        PH_WR_A: scl_nxt = 1'b0;
        PH_WR_B: begin
          sda_nxt   = shift_nxt[7];
          shift_nxt = {shift_nxt[6:0], 1'b0};
        end
        PH_WR_C: scl_nxt = 1'b1;
        PH_WR_E: scl_nxt = 1'b0;
        PH_RD_R: sda_nxt = 1'b1;
        PH_RD_A: scl_nxt = 1'b0;
        PH_RD_B: scl_nxt = 1'b1;
        PH_RD_E: scl_nxt = 1'b0;
        PH_WA_R: sda_nxt = 1'b1;
        PH_WA_H: scl_nxt = 1'b1;
        PH_WA_E: scl_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  // Advance the sequencer once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cmd_r     <= OP_START;
      bit_r     <= 4'd0;
      shift_r   <= 8'd0;
      tick_r    <= 8'd0;
      poll_r    <= 8'd0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      ack_err_r <= 1'b0;
      rx_r      <= 8'd0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      cmd_r     <= cmd_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      tick_r    <= tick_nxt;
      poll_r    <= poll_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      ack_err_r <= ack_err_nxt;
      rx_r      <= rx_nxt;
    end
  end

  // Result for this tick
  always_comb begin
    res.scl_level   = scl_nxt;
    res.sda_release = sda_nxt;
    res.busy_res    = (phase_nxt != PH_IDLE);
    res.done_res    = done;
    res.read_data   = rx_nxt;
    res.ack_missing = ack_err_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/i2cm_out_stage.sv =====
`default_nettype none
module i2cm_out_stage (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  i2cm_pkg::res_t res,
  output logic           in_ready,
  i2cm_out_if.source     out_ch
);
  import i2cm_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  // Take a new tick whenever the result register is empty or being drained
  assign in_ready = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (step)              valid_nxt = 1'b1;
    else if (out_ch.ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  // Hold the result payload until the next request is taken
  always_ff @(posedge clk) begin
    if (step) res_r <= res;
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.scl_level   = res_r.scl_level;
  assign out_ch.sda_release = res_r.sda_release;
  assign out_ch.busy_res    = res_r.busy_res;
  assign out_ch.done_res    = res_r.done_res;
  assign out_ch.read_data   = res_r.read_data;
  assign out_ch.ack_missing = res_r.ack_missing;

endmodule
`default_nettype wire

// ===== rtl/i2cm_checker.sv =====
`default_nettype none
module i2cm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_busy,
  input wire logic out_done
);

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // No new request while a stalled result fills the register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken over a stalled result");

  // A finishing command leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> !out_busy)
    else $error("done reported while still busy");

  // Every accepted request shows a result on the next cycle
  a_req_res: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

endmodule

bind i2c_bit_level_master_top i2cm_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_busy  (out_chan.busy_res),
  .out_done  (out_chan.done_res)
);
`default_nettype wire

// ===== bench/i2c_bit_level_master_top_test.sv =====
`default_nettype none
module i2c_bit_level_master_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  // Operation code with no command behind it
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int SETTLE_CYCLES  = 8;
  localparam int QUIET_LIMIT    = 4000;
  localparam int RANDOM_TICKS   = 550;

  // How the far end drives SDA while a command runs
  typedef enum int {
    LINE_RANDOM,
    LINE_LOW,
    LINE_HIGH,
    LINE_SLOW_ACK
  } line_mode_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;

  i2cm_in_if  in_chan ();
  i2cm_out_if out_chan ();

  i2c_bit_level_master_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Sequencer copy kept in step with accepted requests
  phase_t     bus_phase;
  logic [2:0] cur_op;
  logic [3:0] bit_cnt;
  logic [7:0] shift_reg;
  logic [7:0] tick_cnt;
  logic [7:0] poll_cnt;
  logic [7:0] rx_byte;
  logic       scl_lvl;
  logic       sda_lvl;
  logic       ack_err;
  logic [7:0] cfg_phase_ticks;
  logic [7:0] cfg_poll_limit;

  res_t pending_levels[$];
  int   mismatch_cnt;
  int   ticks_sent;
  int   burst_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Enter a bus phase and apply its line change
  function automatic void enter_phase(phase_t p);
    bus_phase = p;
    tick_cnt  = 8'd0;
    case (p)
      PH_ST_A: begin
        sda_lvl = 1'b1;
        scl_lvl = 1'b1;
      end
      PH_ST_B: sda_lvl = 1'b0;
      PH_ST_C: scl_lvl = 1'b0;
      PH_SP_A: scl_lvl = 1'b0;
      PH_SP_B: sda_lvl = 1'b0;
      PH_SP_C: scl_lvl = 1'b1;
      PH_SP_D: sda_lvl = 1'b1;
      PH_AK_A: scl_lvl = 1'b0;
      PH_AK_B: sda_lvl = (cur_op == OP_NACK);
      PH_AK_C: scl_lvl = 1'b1;
      PH_AK_D: scl_lvl = 1'b0;
      PH_WR_A: scl_lvl = 1'b0;
      PH_WR_B: begin
        sda_lvl   = shift_reg[7];
        shift_reg = {shift_reg[6:0], 1'b0};
      end
      PH_WR_C: scl_lvl = 1'b1;
      PH_WR_E: scl_lvl = 1'b0;
      PH_RD_R: sda_lvl = 1'b1;
      PH_RD_A: scl_lvl = 1'b0;
      PH_RD_B: scl_lvl = 1'b1;
      PH_RD_E: scl_lvl = 1'b0;
      PH_WA_R: sda_lvl = 1'b1;
      PH_WA_H: scl_lvl = 1'b1;
      PH_WA_E: scl_lvl = 1'b0;
      default: ;
    endcase
  endfunction

  // Close the current phase once it has held its full length; 1 on completion
  function automatic logic close_phase(logic sda);
    close_phase = 1'b0;
    case (bus_phase)
      PH_ST_C, PH_SP_D, PH_AK_D, PH_WR_E, PH_WA_E: begin
        bus_phase   = PH_IDLE;
        tick_cnt    = 8'd0;
        close_phase = 1'b1;
      end
      PH_RD_E: begin
        rx_byte     = shift_reg;
        bus_phase   = PH_IDLE;
        tick_cnt    = 8'd0;
        close_phase = 1'b1;
      end
      PH_WR_C: begin
        bit_cnt = bit_cnt + 4'd1;
        enter_phase(bit_cnt >= 4'd8 ? PH_WR_E : PH_WR_A);
      end
      PH_RD_B: begin
        shift_reg = {shift_reg[6:0], sda};
        bit_cnt   = bit_cnt + 4'd1;
        enter_phase(bit_cnt >= 4'd8 ? PH_RD_E : PH_RD_A);
      end
      PH_WA_H, PH_WA_P: begin
        if (!sda) begin
          enter_phase(PH_WA_E);
        end else if (poll_cnt >= cfg_poll_limit) begin
          // Give up: flag the missing ack and run a stop
          ack_err = 1'b1;
          enter_phase(PH_SP_A);
        end else begin
          poll_cnt = poll_cnt + 8'd1;
          enter_phase(PH_WA_P);
        end
      end
      default: enter_phase(phase_t'(bus_phase + 5'd1));
    endcase
  endfunction

  // Advance the sequencer copy by one tick and return the line levels it drives
  function automatic res_t predict_bus_levels(logic cv, logic [2:0] op, logic [7:0] wd,
                                              logic sda);
    res_t r;
    int   span;
    logic done;
    span = (cfg_phase_ticks == 8'd0) ? 1 : int'(cfg_phase_ticks);
    done = 1'b0;
    if (bus_phase == PH_IDLE) begin
      if (cv && op != OP_UNUSED) begin
        cur_op  = op;
        bit_cnt = 4'd0;
        case (op)
          OP_START: enter_phase(PH_ST_A);
          OP_STOP:  enter_phase(PH_SP_A);
          OP_WRITE: begin
            shift_reg = wd;
            enter_phase(PH_WR_A);
          end
          OP_READ: begin
            shift_reg = 8'd0;
            enter_phase(PH_RD_R);
          end
          OP_ACK, OP_NACK: enter_phase(PH_AK_A);
          default: begin
            ack_err  = 1'b0;
            poll_cnt = 8'd0;
            enter_phase(PH_WA_R);
          end
        endcase
      end
    end else if (int'(tick_cnt) + 1 >= span) begin
      done = close_phase(sda);
    end else begin
      tick_cnt = tick_cnt + 8'd1;
    end
    r.scl_level   = scl_lvl;
    r.sda_release = sda_lvl;
    r.busy_res    = (bus_phase != PH_IDLE);
    r.done_res    = done;
    r.read_data   = rx_byte;
    r.ack_missing = ack_err;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [7:0] exp, logic [7:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      mismatch_cnt++;
    end
  endfunction

  function automatic logic line_level(line_mode_t mode);
    case (mode)
      LINE_LOW:      return 1'b0;
      LINE_HIGH:     return 1'b1;
      LINE_SLOW_ACK: return ($urandom_range(0, 99) < 85);
      default:       return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Send one tick, predict its result, then leave a random gap
  task automatic send_tick(logic cv, logic [2:0] op, logic [7:0] wd, logic sda);
    int gap;
    in_chan.cmd_valid  <= cv;
    in_chan.operation  <= op;
    in_chan.write_data <= wd;
    in_chan.sda_in     <= sda;
    in_chan.valid      <= 1'b1;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    pending_levels.push_back(predict_bus_levels(cv, op, wd, sda));
    ticks_sent++;
    // Mostly back to back, some short gaps, a few long ones
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:7]:   burst_left = $urandom_range(16, 96);
        [8:59]:  gap = 0;
        [60:91]: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(4, 24);
      endcase
    end
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Issue a command on an idle tick and keep ticking until it completes
  task automatic run_command(logic [2:0] op, logic [7:0] wd, line_mode_t mode);
    send_tick(1'b1, op, wd, line_level(mode));
    while (bus_phase != PH_IDLE) begin
      // Commands offered while busy must be dropped
      if ($urandom_range(0, 19) == 0)
        send_tick(1'b1, 3'($urandom_range(0, 7)), 8'($urandom), line_level(mode));
      else
        send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), line_level(mode));
    end
  endtask

  // Hold requests until every expected result is back, then let the block settle
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    drain_results();
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PHASE_TICKS)
      cfg_phase_ticks = val;
    else
      cfg_poll_limit = val;
    @(posedge clk);
  endtask

  function automatic line_mode_t pick_ack_mode();
    case ($urandom_range(0, 99)) inside
      [0:49]:  return LINE_LOW;
      [50:74]: return LINE_SLOW_ACK;
      [75:89]: return LINE_HIGH;
      default: return LINE_RANDOM;
    endcase
  endfunction

  // Idle ticks, ignored code and the field extremes
  task automatic test_idle_ticks();
    send_tick(1'b0, OP_START, 8'h00, 1'b0);
    send_tick(1'b0, OP_UNUSED, 8'hFF, 1'b1);
    send_tick(1'b1, OP_UNUSED, 8'hFF, 1'b0);
    send_tick(1'b1, OP_UNUSED, 8'h00, 1'b1);
    send_tick(1'b0, OP_WAIT_ACK, 8'h5A, 1'b0);
  endtask

  // Every command at least once at the reset phase length
  task automatic test_each_command();
    run_command(OP_START, 8'h00, LINE_RANDOM);
    run_command(OP_WRITE, 8'h00, LINE_RANDOM);
    run_command(OP_WAIT_ACK, 8'h00, LINE_LOW);
    run_command(OP_WRITE, 8'hFF, LINE_RANDOM);
    run_command(OP_WAIT_ACK, 8'hFF, LINE_SLOW_ACK);
    run_command(OP_READ, 8'h00, LINE_HIGH);
    run_command(OP_ACK, 8'h00, LINE_RANDOM);
    run_command(OP_READ, 8'hFF, LINE_LOW);
    run_command(OP_ACK, 8'h00, LINE_RANDOM);
    run_command(OP_READ, 8'h3C, LINE_RANDOM);
    run_command(OP_NACK, 8'h00, LINE_RANDOM);
    run_command(OP_STOP, 8'h00, LINE_RANDOM);
  endtask

  // Phase length zero counts as one; then the longest, then a length of two
  task automatic test_phase_length();
    write_reg(CFG_PHASE_TICKS, 8'd0);
    run_command(OP_START, 8'h00, LINE_RANDOM);
    run_command(OP_WRITE, 8'hA5, LINE_RANDOM);
    run_command(OP_STOP, 8'h00, LINE_RANDOM);
    write_reg(CFG_PHASE_TICKS, 8'd255);
    run_command(OP_START, 8'h00, LINE_RANDOM);
    write_reg(CFG_PHASE_TICKS, 8'd2);
    run_command(OP_NACK, 8'h00, LINE_RANDOM);
    run_command(OP_READ, 8'h00, LINE_RANDOM);
    write_reg(CFG_PHASE_TICKS, 8'd1);
  endtask

  // Ack polling: timeout at the smallest and largest limits, then a clean ack
  task automatic test_ack_timeout();
    write_reg(CFG_ACK_POLL_LIMIT, 8'd0);
    run_command(OP_WAIT_ACK, 8'h00, LINE_HIGH);
    write_reg(CFG_ACK_POLL_LIMIT, 8'd1);
    run_command(OP_WAIT_ACK, 8'h00, LINE_HIGH);
    run_command(OP_WAIT_ACK, 8'h00, LINE_SLOW_ACK);
    write_reg(CFG_ACK_POLL_LIMIT, 8'd255);
    run_command(OP_WAIT_ACK, 8'h00, LINE_HIGH);
    run_command(OP_WAIT_ACK, 8'h00, LINE_LOW);
  endtask

  // One bus transaction, occasionally broken or replaced by a stray command
  task automatic run_transfer();
    int n_data;
    if ($urandom_range(0, 99) < 15) begin
      run_command(3'($urandom_range(0, 7)), 8'($urandom),
                  line_mode_t'($urandom_range(0, 3)));
      return;
    end
    run_command(OP_START, 8'($urandom), LINE_RANDOM);
    run_command(OP_WRITE, 8'($urandom), LINE_RANDOM);
    run_command(OP_WAIT_ACK, 8'($urandom), pick_ack_mode());
    n_data = $urandom_range(0, 3);
    for (int i = 0; i < n_data; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        run_command(OP_WRITE, 8'($urandom), LINE_RANDOM);
        run_command(OP_WAIT_ACK, 8'($urandom), pick_ack_mode());
      end else begin
        run_command(OP_READ, 8'($urandom), LINE_RANDOM);
        run_command((i == n_data - 1) ? OP_NACK : OP_ACK, 8'($urandom), LINE_RANDOM);
      end
    end
    if ($urandom_range(0, 9) != 0) run_command(OP_STOP, 8'($urandom), LINE_RANDOM);
    repeat ($urandom_range(0, 3))
      send_tick(1'($urandom_range(0, 1)), OP_UNUSED, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Rounds of random transactions, each at a fresh setting
  task automatic test_random_transfers();
    int first_tick;
    int round_end;
    first_tick = ticks_sent;
    while (ticks_sent - first_tick < RANDOM_TICKS) begin
      case ($urandom_range(0, 99)) inside
        [0:59]:  write_reg(CFG_PHASE_TICKS, 8'd1);
        [60:84]: write_reg(CFG_PHASE_TICKS, 8'($urandom_range(2, 3)));
        [85:94]: write_reg(CFG_PHASE_TICKS, 8'($urandom_range(4, 8)));
        default: write_reg(CFG_PHASE_TICKS, 8'd0);
      endcase
      case ($urandom_range(0, 99)) inside
        [0:69]:  write_reg(CFG_ACK_POLL_LIMIT, 8'($urandom_range(0, 8)));
        [70:89]: write_reg(CFG_ACK_POLL_LIMIT, 8'($urandom_range(9, 40)));
        default: write_reg(CFG_ACK_POLL_LIMIT, 8'($urandom_range(200, 255)));
      endcase
      round_end = ticks_sent + $urandom_range(150, 350);
      while (ticks_sent < round_end) run_transfer();
    end
  endtask

  // Result side: random stalls on ready, check each accepted result
  initial begin : result_side
    int   stall_left;
    int   free_left;
    res_t want;
    stall_left = 0;
    free_left  = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        if (pending_levels.size() == 0) begin
          $error("result with no request waiting");
          mismatch_cnt++;
        end else begin
          want = pending_levels.pop_front();
          compare_field("scl_level", want.scl_level, out_chan.scl_level);
          compare_field("sda_release", want.sda_release, out_chan.sda_release);
          compare_field("busy_res", want.busy_res, out_chan.busy_res);
          compare_field("done_res", want.done_res, out_chan.done_res);
          compare_field("read_data", want.read_data, out_chan.read_data);
          compare_field("ack_missing", want.ack_missing, out_chan.ack_missing);
        end
      end
      // Shape the stalls: free stretches, short holds, now and then a long one
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if (free_left > 0) begin
          free_left--;
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:9]:   free_left  = $urandom_range(20, 200);
            [10:39]: stall_left = $urandom_range(1, 3);
            [40:42]: stall_left = $urandom_range(10, 40);
            default: ;
          endcase
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no request or result moving
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("i2c_bit_level_master_top: mismatch");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_PHASE_TICKS;
    cfg_wdata          <= 8'd0;
    in_chan.valid      <= 1'b0;
    in_chan.cmd_valid  <= 1'b0;
    in_chan.operation  <= OP_START;
    in_chan.write_data <= 8'd0;
    in_chan.sda_in     <= 1'b1;
    mismatch_cnt = 0;
    ticks_sent   = 0;
    burst_left   = 0;
    // Reset state of the sequencer copy
    bus_phase       = PH_IDLE;
    cur_op          = OP_START;
    bit_cnt         = 4'd0;
    shift_reg       = 8'd0;
    tick_cnt        = 8'd0;
    poll_cnt        = 8'd0;
    rx_byte         = 8'd0;
    scl_lvl         = 1'b1;
    sda_lvl         = 1'b1;
    ack_err         = 1'b0;
    cfg_phase_ticks = PHASE_TICKS_RST;
    cfg_poll_limit  = ACK_POLL_LIMIT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_each_command();
    test_phase_length();
    test_ack_timeout();
    test_random_transfers();

    drain_results();
    if (pending_levels.size() != 0) begin
      $error("%0d expected results never arrived", pending_levels.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("i2c_bit_level_master_top: match");
    end else begin
      $display("i2c_bit_level_master_top: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2cm_seq.sv
rtl/i2cm_out_stage.sv
rtl/i2c_bit_level_master_top.sv
rtl/i2cm_checker.sv
bench/i2c_bit_level_master_top_test.sv
